### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the MED predictor.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/mpr_pkg.sv
// Package for the MED predictor and residual block.
// Holds sizes, register indexes and the median edge detector function; no dependencies.
`timescale 1ns / 1ps
package mpr_pkg;
	localparam int MAX_WIDTH    = 4096;
	localparam int HEIGHT_LIMIT = 4096;
	localparam int PIX_W        = 8;
	localparam int CFG_W        = 13;
	localparam int COL_W        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
	localparam int WCMP_W       = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
	localparam int IDX_W        = 1;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [CFG_W-1:0] cfg_t;
	typedef logic [COL_W-1:0] col_t;
	typedef logic [ROW_W-1:0] row_t;

	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	function automatic pix_t med_predict(input pix_t a, input pix_t b, input pix_t c);
		pix_t lo;
		pix_t hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (c >= hi) begin
			return lo;
		end else if (c <= lo) begin
			return hi;
		end else begin
			return pix_t'(a + b - c);
		end
	endfunction
endpackage

### rtl/med_predictor_residual_core.sv
// Median edge detector predictor and residual, one 8-bit plane in raster order.
// Depends on mpr_pkg and assert_macros.svh.
//
//   channel   direction  signals
//   pixel     in         pixel_valid, pixel_ready, pixel_value, frame_start
//   result    out        result_valid, result_ready, residual, prediction, frame_end
//   config    in         cfg_we, cfg_index, cfg_data
//
// One word per clock if result_ready stays high; each word passes stage one, then the output register.
// The line store is read and written at the accept edge (read before write), so the
// row above is always current without forwarding.
// Reset clears position, neighbor registers and valid flags; the line store is not cleared.
// A stalled result holds the output register; a word in stage one waits behind it.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module med_predictor_residual_core
	import mpr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pixel_valid,
	output logic              pixel_ready,
	input  pix_t              pixel_value,
	input  logic              frame_start,
	output logic              result_valid,
	input  logic              result_ready,
	output pix_t              residual,
	output pix_t              prediction,
	output logic              frame_end,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  cfg_t              cfg_data
);
	cfg_t              width_q;
	cfg_t              height_q;
	col_t              col_q;
	row_t              row_q;
	pix_t              left_q;
	pix_t              upl_q;
	pix_t              row_mem [MAX_WIDTH];

	logic              in_acc;
	logic              s1_adv;
	col_t              col_cur;
	row_t              row_cur;
	logic [WCMP_W-1:0] w_ext;
	logic [WCMP_W-1:0] w_eff;
	cfg_t              h_eff;
	logic              last_col;
	logic              last_row;

	logic              valid_s1;
	pix_t              x_s1;
	pix_t              rd_s1;
	logic              row0_s1;
	logic              col0_s1;
	logic              end_s1;

	pix_t              a_v;
	pix_t              b_v;
	pix_t              c_v;
	pix_t              pred_v;

	logic              valid_s2;
	pix_t              res_s2;
	pix_t              pred_s2;
	logic              end_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= cfg_t'(MAX_WIDTH);
			height_q <= cfg_t'(HEIGHT_LIMIT);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_acc      = pixel_valid && pixel_ready;
	assign s1_adv      = valid_s1 && (!valid_s2 || result_ready);
	assign pixel_ready = !valid_s1 || s1_adv;

	always_comb begin
		col_cur = frame_start ? '0 : col_q;
		row_cur = frame_start ? '0 : row_q;
		w_ext   = WCMP_W'(width_q);
		if (w_ext == '0) begin
			w_eff = WCMP_W'(1);
		end else if (w_ext > WCMP_W'(MAX_WIDTH)) begin
			w_eff = WCMP_W'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		if (height_q == '0) begin
			h_eff = cfg_t'(1);
		end else if (height_q > cfg_t'(HEIGHT_LIMIT)) begin
			h_eff = cfg_t'(HEIGHT_LIMIT);
		end else begin
			h_eff = height_q;
		end
		last_col = (WCMP_W'(col_cur) + WCMP_W'(1)) >= w_eff;
		last_row = (CFG_W'(row_cur) + CFG_W'(1)) >= h_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_t'(row_cur + row_t'(1));
			end else begin
				col_q <= col_t'(col_cur + col_t'(1));
				row_q <= row_cur;
			end
		end
	end

	// line store: read before write at the same address
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_s1            <= row_mem[col_cur];
			row_mem[col_cur] <= pixel_value;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_s1    <= pixel_value;
			row0_s1 <= (row_cur == '0);
			col0_s1 <= (col_cur == '0);
			end_s1  <= last_col && last_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_comb begin
		a_v    = col0_s1 ? '0 : left_q;
		b_v    = row0_s1 ? '0 : rd_s1;
		c_v    = (row0_s1 || col0_s1) ? '0 : upl_q;
		pred_v = med_predict(a_v, b_v, c_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			upl_q  <= '0;
		end else if (s1_adv) begin
			left_q <= x_s1;
			upl_q  <= b_v;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_s2  <= pix_t'(x_s1 - pred_v);
			pred_s2 <= pred_v;
			end_s2  <= end_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	assign result_valid = valid_s2;
	assign residual     = res_s2;
	assign prediction   = pred_s2;
	assign frame_end    = end_s2;

	`ASSERT_CLK(a_s1_hold, (valid_s1 && !s1_adv) |=> (valid_s1 && $stable(x_s1)), "stage one word lost while blocked")
	`ASSERT_CLK(a_col_wrap, (in_acc && last_col) |=> (col_q == '0), "column did not wrap after last column")
	`ASSERT_CLK(a_col_step, (in_acc && !last_col) |=> (col_q == col_t'($past(col_cur) + col_t'(1))), "column did not advance by one")
	`ASSERT_ALWAYS(a_rst_empty, !arst_n |-> (!valid_s1 && !valid_s2), "pipeline not empty in reset")
endmodule
